[rtl/core/atrlc_pkg.sv]
// shared types and constants for the at response line classifier
// no dependencies; imported by every module of the block
`default_nettype none

package atrlc_pkg;

   // operation codes of an input transaction
   localparam logic OP_RX_BYTE   = 1'b0;
   localparam logic OP_CMD_ISSUE = 1'b1;

   // line kind codes of a result
   localparam logic [1:0] KIND_URC = 2'd0;
   localparam logic [1:0] KIND_MID = 2'd1;
   localparam logic [1:0] KIND_OK  = 2'd2;
   localparam logic [1:0] KIND_ERR = 2'd3;

   localparam logic [7:0] CHAR_LF = 8'h0a;
   localparam logic [7:0] CHAR_CR = 8'h0d;

   localparam int OK_LEN     = 2;
   localparam int ERROR_LEN  = 5;
   localparam int PREFIX_LEN = 11;

   localparam logic [7:0] PAT_OK [OK_LEN] = '{"O", "K"};
   localparam logic [7:0] PAT_ERROR [ERROR_LEN] = '{"E", "R", "R", "O", "R"};
   localparam logic [7:0] PAT_CME [PREFIX_LEN] =
      '{"+", "C", "M", "E", " ", "E", "R", "R", "O", "R", ":"};
   localparam logic [7:0] PAT_CMS [PREFIX_LEN] =
      '{"+", "C", "M", "S", " ", "E", "R", "R", "O", "R", ":"};

   // match flag bit positions
   localparam int FLAG_OK  = 0;
   localparam int FLAG_ERR = 1;
   localparam int FLAG_CME = 2;
   localparam int FLAG_CMS = 3;

   typedef struct packed {
      logic        operation;
      logic [7:0]  rx_byte;
      logic [15:0] command_id;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  line_kind;
      logic [7:0]  line_length;
      logic [15:0] owner_id;
      logic [7:0]  response_length;
      logic        line_appended;
   } rsp_payload_type;

   // line summary handed from the framer to the response tracker
   typedef struct packed {
      logic line_end;
      logic is_ok;
      logic is_err;
   } line_event_type;

endpackage

`default_nettype wire

[rtl/core/atrlc_line_framer.sv]
// frames received bytes into lines and tracks keyword matches per line
// depends on atrlc_pkg
`default_nettype none

module atrlc_line_framer #(
   parameter int LINE_BYTES = 256,
   localparam int CW = $clog2(LINE_BYTES)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [7:0]               rx_byte,
   output atrlc_pkg::line_event_type     line_event,
   output logic [CW-1:0]                 line_length
);
   import atrlc_pkg::*;

   logic [CW-1:0] count_ff, count_in;
   logic          zero_seen_ff, zero_seen_in;
   logic [CW-1:0] zero_pos_ff, zero_pos_in;
   logic          last_cr_ff, last_cr_in;
   logic [3:0]    flags_ff, flags_in;
   logic [3:0]    byte_flags;
   logic [CW-1:0] len;
   logic          is_lf;

   // per-byte pattern compare at the current position
   always_comb begin
      byte_flags = flags_ff;
      if (count_ff < CW'(OK_LEN) && rx_byte != PAT_OK[count_ff[0]])
         byte_flags[FLAG_OK] = 1'b0;
      if (count_ff < CW'(ERROR_LEN) && rx_byte != PAT_ERROR[count_ff[2:0]])
         byte_flags[FLAG_ERR] = 1'b0;
      if (count_ff < CW'(PREFIX_LEN) && rx_byte != PAT_CME[count_ff[3:0]])
         byte_flags[FLAG_CME] = 1'b0;
      if (count_ff < CW'(PREFIX_LEN) && rx_byte != PAT_CMS[count_ff[3:0]])
         byte_flags[FLAG_CMS] = 1'b0;
   end

   // effective length: trailing cr stripped, cut at first zero byte
   always_comb begin
      len = count_ff;
      if (count_ff != '0 && last_cr_ff)
         len = count_ff - CW'(1);
      if (zero_seen_ff && zero_pos_ff < len)
         len = zero_pos_ff;
   end

   assign is_lf = (rx_byte == CHAR_LF);

   always_comb begin
      line_event.line_end = step && is_lf;
      line_event.is_ok    = flags_ff[FLAG_OK] && len == CW'(OK_LEN);
      line_event.is_err   = (flags_ff[FLAG_ERR] && len == CW'(ERROR_LEN))
                          || ((flags_ff[FLAG_CME] || flags_ff[FLAG_CMS])
                              && len >= CW'(PREFIX_LEN));
      line_length = len;
   end

   always_comb begin
      count_in     = count_ff;
      zero_seen_in = zero_seen_ff;
      zero_pos_in  = zero_pos_ff;
      last_cr_in   = last_cr_ff;
      flags_in     = flags_ff;
      if (step) begin
         if (is_lf) begin
            count_in     = '0;
            zero_seen_in = 1'b0;
            zero_pos_in  = '0;
            last_cr_in   = 1'b0;
            flags_in     = 4'hf;
         end else if (count_ff < CW'(LINE_BYTES - 1)) begin
            if (!zero_seen_ff) begin
               if (rx_byte == 8'h00) begin
                  zero_seen_in = 1'b1;
                  zero_pos_in  = count_ff;
               end else begin
                  flags_in = byte_flags;
               end
            end
            last_cr_in = (rx_byte == CHAR_CR);
            count_in   = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         zero_seen_ff <= 1'b0;
         zero_pos_ff  <= '0;
         last_cr_ff   <= 1'b0;
         flags_ff     <= 4'hf;
      end else begin
         count_ff     <= count_in;
         zero_seen_ff <= zero_seen_in;
         zero_pos_ff  <= zero_pos_in;
         last_cr_ff   <= last_cr_in;
         flags_ff     <= flags_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/atrlc_resp_tracker.sv]
// tracks the busy command and its accumulated response length, builds results
// depends on atrlc_pkg
`default_nettype none

module atrlc_resp_tracker #(
   parameter int LINE_BYTES     = 256,
   parameter int RESPONSE_BYTES = 256,
   localparam int CW = $clog2(LINE_BYTES),
   localparam int AW = $clog2(RESPONSE_BYTES),
   localparam int SW = ((AW > CW) ? AW : CW) + 2
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire logic                      operation,
   input  wire logic [15:0]               command_id,
   input  wire atrlc_pkg::line_event_type line_event,
   input  wire logic [CW-1:0]             line_length,
   output logic                           result_valid,
   output atrlc_pkg::rsp_payload_type     result
);
   import atrlc_pkg::*;

   logic          busy_ff, busy_in;
   logic [15:0]   id_ff, id_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [SW-1:0] need;
   logic          fits;
   logic [AW-1:0] acc_app;
   logic [AW-1:0] acc_after;
   logic          terminal;
   logic          line_done;

   assign line_done = line_event.line_end && line_length != '0;

   // a line fits when accumulated + length + 2 stays below the limit
   assign need     = SW'(acc_ff) + SW'(line_length) + SW'(2);
   assign fits     = need < SW'(RESPONSE_BYTES);
   assign acc_app  = acc_ff + AW'(acc_ff != '0) + AW'(line_length);
   assign acc_after = fits ? acc_app : acc_ff;
   assign terminal = line_event.is_ok || line_event.is_err;

   always_comb begin
      result_valid           = step && operation == OP_RX_BYTE && line_done;
      result.line_length     = 8'(line_length);
      if (busy_ff) begin
         if (line_event.is_ok)
            result.line_kind = KIND_OK;
         else if (line_event.is_err)
            result.line_kind = KIND_ERR;
         else
            result.line_kind = KIND_MID;
         result.owner_id        = id_ff;
         result.response_length = 8'(acc_after);
         result.line_appended   = fits;
      end else begin
         result.line_kind       = KIND_URC;
         result.owner_id        = '0;
         result.response_length = 8'(acc_ff);
         result.line_appended   = 1'b0;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      id_in   = id_ff;
      acc_in  = acc_ff;
      if (step) begin
         if (operation == OP_CMD_ISSUE) begin
            busy_in = 1'b1;
            id_in   = command_id;
            acc_in  = '0;
         end else if (line_done && busy_ff) begin
            if (terminal) begin
               busy_in = 1'b0;
               id_in   = '0;
               acc_in  = '0;
            end else begin
               acc_in = acc_after;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         id_ff   <= '0;
         acc_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         id_ff   <= id_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/at_response_line_classifier.sv]
// at response line classifier: input register, single pass of line framing and
// response tracking, then a result register.
// a byte waits in the input register until the result register can take its result.
// throughput: 1 transaction per cycle while rsp_ready keeps the result register free.
// reset: synchronous, clears line framing, busy command and response length.
// depends on atrlc_pkg, atrlc_line_framer, atrlc_resp_tracker
`default_nettype none

module at_response_line_classifier #(
   parameter int LINE_BYTES     = 256,
   parameter int RESPONSE_BYTES = 256
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire atrlc_pkg::req_payload_type req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output atrlc_pkg::rsp_payload_type      rsp_data
);
   import atrlc_pkg::*;

   localparam int CW = $clog2(LINE_BYTES);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff, in_data_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   logic            fire;
   logic            framer_step;
   line_event_type  line_event;
   logic [CW-1:0]   line_length;
   logic            result_valid;
   rsp_payload_type result;

   // process the held transaction when the result register can take it
   assign fire        = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || fire;
   assign framer_step = fire && in_data_ff.operation == OP_RX_BYTE;

   atrlc_line_framer #(
      .LINE_BYTES(LINE_BYTES)
   ) u_framer (
      .clock       (clock),
      .reset       (reset),
      .step        (framer_step),
      .rx_byte     (in_data_ff.rx_byte),
      .line_event  (line_event),
      .line_length (line_length)
   );

   atrlc_resp_tracker #(
      .LINE_BYTES     (LINE_BYTES),
      .RESPONSE_BYTES (RESPONSE_BYTES)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .step         (fire),
      .operation    (in_data_ff.operation),
      .command_id   (in_data_ff.command_id),
      .line_event   (line_event),
      .line_length  (line_length),
      .result_valid (result_valid),
      .result       (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (fire) begin
         out_valid_in = result_valid;
         if (result_valid)
            out_data_in = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

[tb/sv/atrlc_line_checker.sv]
`timescale 1ns / 100ps
// line checker for the at response line classifier: tracks line framing and
// the busy command from accepted requests, queues the expected result of every
// completed line and compares it with the result channel; depends on atrlc_pkg
module atrlc_line_checker #(
   parameter int LINE_BYTES     = 256,
   parameter int RESPONSE_BYTES = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  atrlc_pkg::req_payload_type req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  atrlc_pkg::rsp_payload_type rsp_data,
   output int                         fail_count,
   output int                         pending_count
);
   import atrlc_pkg::*;

   localparam logic [87:0] OK_TEXT    = "OK";
   localparam logic [87:0] ERROR_TEXT = "ERROR";
   localparam logic [87:0] CME_TEXT   = "+CME ERROR:";
   localparam logic [87:0] CMS_TEXT   = "+CMS ERROR:";

   int          line_fill;
   logic        nul_seen;
   int          nul_at;
   logic        ends_in_cr;
   logic [3:0]  prefix_alive;
   logic        cmd_open;
   logic [15:0] cmd_owner;
   int          resp_total;

   rsp_payload_type expected_lines[$];

   function automatic logic [7:0] text_byte(input logic [87:0] text, input int n,
                                            input int pos);
      return text[8*(n-1-pos) +: 8];
   endfunction

   task automatic clear_line();
      line_fill    = 0;
      nul_seen     = 1'b0;
      nul_at       = 0;
      ends_in_cr   = 1'b0;
      prefix_alive = 4'hf;
   endtask

   task automatic match_prefixes(input int pos, input logic [7:0] b);
      if (pos < OK_LEN && b != text_byte(OK_TEXT, OK_LEN, pos))
         prefix_alive[FLAG_OK] = 1'b0;
      if (pos < ERROR_LEN && b != text_byte(ERROR_TEXT, ERROR_LEN, pos))
         prefix_alive[FLAG_ERR] = 1'b0;
      if (pos < PREFIX_LEN && b != text_byte(CME_TEXT, PREFIX_LEN, pos))
         prefix_alive[FLAG_CME] = 1'b0;
      if (pos < PREFIX_LEN && b != text_byte(CMS_TEXT, PREFIX_LEN, pos))
         prefix_alive[FLAG_CMS] = 1'b0;
   endtask

   task automatic track_request(input req_payload_type p);
      int              len;
      logic [1:0]      kind;
      rsp_payload_type line_result;
      if (p.operation == OP_CMD_ISSUE) begin
         // a new command replaces any busy one
         cmd_open   = 1'b1;
         cmd_owner  = p.command_id;
         resp_total = 0;
      end else if (p.rx_byte != CHAR_LF) begin
         if (line_fill < LINE_BYTES - 1) begin
            if (!nul_seen) begin
               if (p.rx_byte == 8'h00) begin
                  nul_seen = 1'b1;
                  nul_at   = line_fill;
               end else begin
                  match_prefixes(line_fill, p.rx_byte);
               end
            end
            ends_in_cr = (p.rx_byte == CHAR_CR);
            line_fill++;
         end
      end else begin
         len = line_fill;
         if (len > 0 && ends_in_cr) len--;
         if (nul_seen && nul_at < len) len = nul_at;
         if (prefix_alive[FLAG_OK] && len == OK_LEN) kind = KIND_OK;
         else if (prefix_alive[FLAG_ERR] && len == ERROR_LEN) kind = KIND_ERR;
         else if ((prefix_alive[FLAG_CME] || prefix_alive[FLAG_CMS]) && len >= PREFIX_LEN)
            kind = KIND_ERR;
         else kind = KIND_MID;
         clear_line();
         if (len != 0) begin
            line_result.line_length   = len[7:0];
            line_result.line_appended = 1'b0;
            if (!cmd_open) begin
               line_result.line_kind       = KIND_URC;
               line_result.owner_id        = 16'h0000;
               line_result.response_length = resp_total[7:0];
            end else begin
               line_result.line_kind = kind;
               line_result.owner_id  = cmd_owner;
               // separator counted only once something is already in the response
               if (resp_total + len + 2 < RESPONSE_BYTES) begin
                  if (resp_total > 0) resp_total++;
                  resp_total += len;
                  line_result.line_appended = 1'b1;
               end
               line_result.response_length = resp_total[7:0];
               if (kind != KIND_MID) begin
                  cmd_open   = 1'b0;
                  cmd_owner  = 16'h0000;
                  resp_total = 0;
               end
            end
            expected_lines.push_back(line_result);
         end
      end
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         clear_line();
         cmd_open   = 1'b0;
         cmd_owner  = 16'h0000;
         resp_total = 0;
         expected_lines.delete();
         fail_count    = 0;
         pending_count = 0;
      end else begin
         if (req_valid && req_ready) track_request(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_lines.size() == 0) begin
               $error("result transaction with no line pending, line_kind %0d length %0d",
                      rsp_data.line_kind, rsp_data.line_length);
               fail_count++;
            end else begin
               want = expected_lines.pop_front();
               check_field("line_kind", int'(want.line_kind), int'(rsp_data.line_kind));
               check_field("line_length", int'(want.line_length),
                           int'(rsp_data.line_length));
               check_field("owner_id", int'(want.owner_id), int'(rsp_data.owner_id));
               check_field("response_length", int'(want.response_length),
                           int'(rsp_data.response_length));
               check_field("line_appended", int'(want.line_appended),
                           int'(rsp_data.line_appended));
            end
         end
         pending_count = expected_lines.size();
      end
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// testbench top: feeds framed at response traffic and command issues into the
// line classifier and gives the verdict; depends on atrlc_pkg,
// atrlc_line_checker and at_response_line_classifier
module tb;
   import atrlc_pkg::*;

   localparam int ITEM_TOTAL   = 1920;
   localparam int STEADY_FROM  = 1650;
   localparam int PRESSURE_AT  = 700;
   localparam int HOLD_CYCLES  = 64;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum int {
      SHAPE_OK, SHAPE_ERROR, SHAPE_CME, SHAPE_CMS, SHAPE_TEXT,
      SHAPE_NOISE, SHAPE_NEAR, SHAPE_EMPTY, SHAPE_LONG
   } line_shape_type;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   int         fail_count;
   int         pending_count;
   int         sent_items    = 0;
   int         idle_cycles   = 0;
   bit         steady        = 1'b0;
   bit         gaps_on       = 1'b1;
   int         hold_requests = 0;
   logic [7:0] text_q[$];

   always #2 clock = ~clock;

   at_response_line_classifier DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   atrlc_line_checker line_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // watchdog: cycles in a row with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin : rsp_side
      int n;
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done < hold_requests) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            holds_done++;
         end else if (!steady && $urandom_range(3) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(9, 1);
            repeat (n - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(12, 1);
            repeat (n - 1) @(posedge clock);
         end
      end
   end

   task automatic push_item(input req_payload_type p);
      int gap;
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      if (!steady && gaps_on && $urandom_range(5) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(9, 1);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_payload_type p;
      p.operation  = OP_RX_BYTE;
      p.rx_byte    = b;
      p.command_id = 16'($urandom);
      push_item(p);
   endtask

   task automatic issue_command(input logic [15:0] id);
      req_payload_type p;
      p.operation  = OP_CMD_ISSUE;
      p.rx_byte    = 8'($urandom);
      p.command_id = id;
      push_item(p);
   endtask

   // stop offering and wait for every pending line result
   task automatic await_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] any_but_lf();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CHAR_LF);
      return b;
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic make_line(input line_shape_type shape);
      int    n;
      int    pick;
      string base;
      text_q.delete();
      case (shape)
         SHAPE_OK:    add_text("OK");
         SHAPE_ERROR: add_text("ERROR");
         SHAPE_CME, SHAPE_CMS: begin
            add_text(shape == SHAPE_CME ? "+CME ERROR:" : "+CMS ERROR:");
            if ($urandom_range(3) != 0) begin
               add_text(" ");
               n = $urandom_range(3, 1);
               repeat (n) text_q.push_back(8'(8'h30 + $urandom_range(9)));
            end
         end
         SHAPE_TEXT: begin
            n = $urandom_range(60, 1);
            repeat (n) text_q.push_back(8'($urandom_range(8'h7e, 8'h20)));
            if ($urandom_range(9) == 0) text_q[$urandom_range(n - 1)] = CHAR_CR;
         end
         SHAPE_NOISE: begin
            n = $urandom_range(24, 1);
            repeat (n) text_q.push_back(any_but_lf());
         end
         SHAPE_NEAR: begin
            // a terminal pattern with one flaw
            pick = $urandom_range(3);
            base = pick == 0 ? "OK" : pick == 1 ? "ERROR" :
                   pick == 2 ? "+CME ERROR:" : "+CMS ERROR:";
            add_text(base);
            case ($urandom_range(3))
               0: text_q[$urandom_range(text_q.size() - 1)] = any_but_lf();
               1: void'(text_q.pop_back());
               2: text_q.push_back(8'($urandom_range(8'h7e, 8'h21)));
               default: while (text_q.size() > base.len() / 2) void'(text_q.pop_back());
            endcase
         end
         SHAPE_LONG: begin
            n = $urandom_range(300, 230);
            repeat (n) text_q.push_back(8'($urandom_range(8'h7e, 8'h20)));
         end
         SHAPE_EMPTY: ;
         default: ;
      endcase
      // zero byte cuts the text, anything after it is ignored
      if ($urandom_range(24) == 0) begin
         text_q.push_back(8'h00);
         n = $urandom_range(4);
         repeat (n) text_q.push_back(any_but_lf());
      end
      if ($urandom_range(1) == 0) text_q.push_back(CHAR_CR);
   endtask

   task automatic send_line(input bit stray_cmds);
      for (int i = 0; i < text_q.size(); i++) begin
         if (stray_cmds && $urandom_range(199) == 0) issue_command(16'($urandom));
         send_byte(text_q[i]);
      end
      send_byte(CHAR_LF);
   endtask

   function automatic line_shape_type middle_shape();
      int r;
      r = $urandom_range(99);
      if (r < 40) return SHAPE_TEXT;
      else if (r < 60) return SHAPE_NOISE;
      else if (r < 80) return SHAPE_NEAR;
      else if (r < 99) return SHAPE_EMPTY;
      else return SHAPE_LONG;
   endfunction

   function automatic line_shape_type final_shape(input int r);
      if (r < 35) return SHAPE_OK;
      else if (r < 55) return SHAPE_ERROR;
      else if (r < 72) return SHAPE_CME;
      else return SHAPE_CMS;
   endfunction

   initial begin : stimulus
      int  r;
      int  n;
      bit  pressure_done;
      pressure_done = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: both operations, id extremes, each line class
      issue_command(16'hffff);
      text_q = '{"O", "K", CHAR_CR};
      send_line(1'b0);
      text_q = '{"Z", "Z"};
      send_line(1'b0);
      issue_command(16'h0000);
      text_q.delete();
      send_line(1'b0);
      text_q = '{"E", "R", "R", "O", "R"};
      send_line(1'b0);
      text_q = '{8'h00, 8'hff};
      send_line(1'b0);
      text_q = '{8'hff, 8'h80};
      send_line(1'b0);
      await_idle();

      while (sent_items < ITEM_TOTAL) begin
         if (!pressure_done && sent_items >= PRESSURE_AT) begin
            // result side held off while short lines keep coming
            pressure_done = 1'b1;
            gaps_on = 1'b0;
            issue_command(16'($urandom));
            hold_requests++;
            repeat (30) begin
               text_q = '{"A", "T"};
               send_line(1'b0);
            end
            await_idle();
         end
         steady  = (sent_items >= STEADY_FROM);
         gaps_on = ($urandom_range(2) != 0);
         if ($urandom_range(9) < 7) begin
            issue_command(16'($urandom));
            n = $urandom_range(6);
            repeat (n) begin
               make_line(middle_shape());
               send_line(1'b1);
            end
            r = $urandom_range(99);
            if (r < 90) begin
               make_line(final_shape(r));
               send_line(1'b1);
            end
         end else begin
            n = $urandom_range(3, 1);
            repeat (n) begin
               make_line(middle_shape());
               send_line(1'b1);
            end
         end
      end

      await_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/atrlc_pkg.sv
rtl/core/atrlc_line_framer.sv
rtl/core/atrlc_resp_tracker.sv
rtl/core/at_response_line_classifier.sv
tb/sv/atrlc_line_checker.sv
tb/sv/tb.sv
